// File: rtl/core/aes_enc_pkg.sv
// ----------------------------------------------------------------------------
// aes_enc_pkg
// shared types, constants and byte functions for the aes encrypt core
// ----------------------------------------------------------------------------
package aes_enc_pkg;

  localparam int unsigned NUM_ROUNDS_MAX = 14;
  localparam int unsigned NUM_WORDS_MAX  = 60;
  localparam int unsigned BLOCK_W        = 128;
  localparam int unsigned HALF_W         = 64;
  localparam int unsigned KEY_W          = 256;
  localparam int unsigned CFG_ADDR_W     = 3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_MODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_0_7  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_8_15 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_16_23 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_24_31 = 3'd4;

  // key length codes
  localparam logic [1:0] KEY_MODE_128 = 2'd0;
  localparam logic [1:0] KEY_MODE_192 = 2'd1;
  localparam logic [1:0] KEY_MODE_256 = 2'd2;

  // what one round stage does
  typedef enum logic [1:0] {
    ROUND_FULL = 2'd0,
    ROUND_LAST = 2'd1,
    ROUND_PASS = 2'd2
  } round_mode_t;

  typedef logic [BLOCK_W-1:0] block_t;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] XT_POLY   = 8'h1B;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    return SBOX[a];
  endfunction

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? XT_POLY : 8'h00);
  endfunction

  // substitute all four bytes of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

endpackage

// File: rtl/core/aes_block_encrypt_core.sv
// throughput: one block per cycle unless out_tready or key expansion stalls it;
// each round is one pipeline stage
// after reset or any config write the key expander runs and in_tready
// stays low until it has finished
// reset: synchronous active low, clears valid bits and key registers
// ----------------------------------------------------------------------------
// aes_block_encrypt_core
// pipelined aes encryption, 128/192/256 bit key, one round per stage
// ----------------------------------------------------------------------------
module aes_block_encrypt_core
  import aes_enc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [HALF_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BLOCK_W-1:0]    in_tdata,   // plain_low, plain_high
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BLOCK_W-1:0]    out_tdata   // cipher_low, cipher_high
);

  localparam int unsigned NSTG = NUM_ROUNDS_MAX + 1;

  logic [1:0]       key_mode_r;
  logic [KEY_W-1:0] key_r;
  logic             kick_r;
  logic             key_busy;
  block_t           rkey [NSTG];
  logic [3:0]       nr;
  block_t           st_r [NSTG];
  logic             v_r  [NSTG];
  logic             en   [NSTG];
  block_t           rnd_out [NSTG];
  round_mode_t      rmode [NSTG];
  logic             in_fire;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= KEY_MODE_128;
      key_r      <= '0;
      kick_r     <= 1'b1;
    end else begin
      kick_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_KEY_MODE:  key_mode_r <= cfg_wdata[1:0];
          CFG_KEY_0_7:   key_r[63:0]    <= cfg_wdata;
          CFG_KEY_8_15:  key_r[127:64]  <= cfg_wdata;
          CFG_KEY_16_23: key_r[191:128] <= cfg_wdata;
          CFG_KEY_24_31: key_r[255:192] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  aes_enc_key u_key (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (kick_r),
    .key_mode_i (key_mode_r),
    .key_i      (key_r),
    .busy_o     (key_busy),
    .rkey_o     (rkey)
  );

  // number of rounds
  always_comb begin
    priority if (key_mode_r == KEY_MODE_128) nr = 4'd10;
    else if (key_mode_r == KEY_MODE_192) nr = 4'd12;
    else nr = 4'd14;
  end

  // stage enables, a bubble lets the stage in front refill
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0] && !kick_r && !key_busy;
  assign in_fire   = in_tvalid && in_tready;

  // round stages
  assign rnd_out[0] = '0;
  assign rmode[0]   = ROUND_PASS;
  for (genvar s = 1; s < NSTG; s++) begin : g_round
    assign rmode[s] = (4'(s) < nr) ? ROUND_FULL :
                      (4'(s) == nr) ? ROUND_LAST : ROUND_PASS;
    aes_enc_round u_round (
      .state_i (st_r[s-1]),
      .rkey_i  (rkey[s]),
      .mode_i  (rmode[s]),
      .state_o (rnd_out[s])
    );
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) v_r[0] <= in_fire;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // data registers, initial key add in stage zero
  always_ff @(posedge clk) begin
    if (en[0]) st_r[0] <= in_tdata ^ rkey[0];
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) st_r[k] <= rnd_out[k];
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = st_r[NSTG-1];

`ifndef ASSERT_OFF
  a_no_accept_while_expanding: assert property (@(posedge clk) disable iff (!rst_n)
    key_busy |-> !in_tready)
    else $error("input accepted during key expansion");

  a_stage0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !en[1]) |=> $stable(st_r[0]) && v_r[0])
    else $error("stalled first stage lost its block");

  a_cfg_kicks_expand: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input ready right after a config write");
`endif

endmodule

// File: rtl/core/aes_enc_round.sv
// ----------------------------------------------------------------------------
// aes_enc_round
// one round: subbytes, shiftrows, mixcolumns (not in last round), key add
// ----------------------------------------------------------------------------
module aes_enc_round
  import aes_enc_pkg::*;
(
  input  block_t      state_i,
  input  block_t      rkey_i,
  input  round_mode_t mode_i,
  output block_t      state_o
);

  logic [7:0] st [16];
  logic [7:0] sb [16];
  logic [7:0] mc [16];
  block_t     sb_vec;
  block_t     mc_vec;

  // unpack, substitute and shift rows
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      st[i] = state_i[8*i +: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[4*c+r] = sub_byte(st[4*((c+r)%4)+r]);
      end
    end
  end

  // mix columns
  always_comb begin
    logic [7:0] t;
    for (int c = 0; c < 4; c++) begin
      t = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
      mc[4*c]   = sb[4*c]   ^ t ^ xtime(sb[4*c]   ^ sb[4*c+1]);
      mc[4*c+1] = sb[4*c+1] ^ t ^ xtime(sb[4*c+1] ^ sb[4*c+2]);
      mc[4*c+2] = sb[4*c+2] ^ t ^ xtime(sb[4*c+2] ^ sb[4*c+3]);
      mc[4*c+3] = sb[4*c+3] ^ t ^ xtime(sb[4*c+3] ^ sb[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      sb_vec[8*i +: 8] = sb[i];
      mc_vec[8*i +: 8] = mc[i];
    end
  end

  // key add, or pass through past the last round
  always_comb begin
    unique case (mode_i)
      ROUND_FULL: state_o = mc_vec ^ rkey_i;
      ROUND_LAST: state_o = sb_vec ^ rkey_i;
      default:    state_o = state_i;
    endcase
  end

endmodule

// File: rtl/core/aes_enc_key.sv
// ----------------------------------------------------------------------------
// aes_enc_key
// round key expansion, one key word per busy cycle into a round key file
// ----------------------------------------------------------------------------
module aes_enc_key
  import aes_enc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [1:0]       key_mode_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             busy_o,
  output block_t           rkey_o [NUM_ROUNDS_MAX+1]
);

  logic [31:0] rk_r  [NUM_WORDS_MAX];
  logic [31:0] win_r [8];
  logic [31:0] win_nxt [8];
  logic [5:0]  idx_r, idx_nxt;
  logic [2:0]  mod_r, mod_nxt;
  logic [7:0]  rc_r, rc_nxt;
  logic        busy_r, busy_nxt;
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] prev_w, far_w, tmp_w, new_w;

  // key length decode
  always_comb begin
    priority if (key_mode_i == KEY_MODE_128) begin
      nk = 4'd4;
      total = 6'd44;
    end else if (key_mode_i == KEY_MODE_192) begin
      nk = 4'd6;
      total = 6'd52;
    end else begin
      nk = 4'd8;
      total = 6'd60;
    end
  end

  // next key word
  always_comb begin
    prev_w = win_r[0];
    unique case (nk)
      4'd4:    far_w = win_r[3];
      4'd6:    far_w = win_r[5];
      default: far_w = win_r[7];
    endcase
    priority if (mod_r == 3'd0) begin
      tmp_w = sub_word({prev_w[7:0], prev_w[31:8]}) ^ {24'h0, rc_r};
    end else if (nk == 4'd8 && mod_r == 3'd4) begin
      tmp_w = sub_word(prev_w);
    end else begin
      tmp_w = prev_w;
    end
    new_w = far_w ^ tmp_w;
  end

  // sequencer control
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    mod_nxt  = mod_r;
    rc_nxt   = rc_r;
    for (int j = 0; j < 8; j++) begin
      win_nxt[j] = win_r[j];
    end
    if (start_i) begin
      busy_nxt = 1'b1;
      idx_nxt  = {2'b00, nk};
      mod_nxt  = 3'd0;
      rc_nxt   = RCON_INIT;
      for (int j = 0; j < 8; j++) begin
        win_nxt[j] = key_i[32*((nk - 4'd1 - 4'(j)) & 4'd7) +: 32];
      end
    end else if (busy_r) begin
      idx_nxt = idx_r + 6'd1;
      mod_nxt = ({1'b0, mod_r} == nk - 4'd1) ? 3'd0 : mod_r + 3'd1;
      if (mod_r == 3'd0) begin
        rc_nxt = xtime(rc_r);
      end
      win_nxt[0] = new_w;
      for (int j = 1; j < 8; j++) begin
        win_nxt[j] = win_r[j-1];
      end
      if (idx_r == total - 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // key file and window
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    mod_r <= mod_nxt;
    rc_r  <= rc_nxt;
    for (int j = 0; j < 8; j++) begin
      win_r[j] <= win_nxt[j];
    end
    if (start_i) begin
      for (int k = 0; k < 8; k++) begin
        rk_r[k] <= key_i[32*k +: 32];
      end
    end else if (busy_r) begin
      rk_r[idx_r] <= new_w;
    end
  end

  assign busy_o = busy_r;

  for (genvar r = 0; r <= NUM_ROUNDS_MAX; r++) begin : g_rkey
    assign rkey_o[r] = {rk_r[4*r+3], rk_r[4*r+2], rk_r[4*r+1], rk_r[4*r]};
  end

endmodule

// File: dv/aes_block_encrypt_core_tb.sv
// ----------------------------------------------------------------------------
// aes_block_encrypt_core_tb
// encrypts directed and random blocks under 128, 192, 256 bit and unused-mode
// keys, predicts each ciphertext with an independent aes model and compares
// every output beat in order, with random idling on both stream sides
// ----------------------------------------------------------------------------
module aes_block_encrypt_core_tb;
  import aes_enc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [HALF_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BLOCK_W-1:0]    in_tdata;   // plain_low, plain_high
  logic                  out_tvalid;
  logic                  out_tready;
  logic [BLOCK_W-1:0]    out_tdata;  // cipher_low, cipher_high

  aes_block_encrypt_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // testbench copy of the key registers
  logic [1:0]  key_mode;
  logic [63:0] key_words [4];

  block_t      plain_q [$];
  block_t      cipher_q [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          failed;

  // sbox computed from the field inverse and affine map, not copied
  logic [7:0] sbox_tb [256];

  function automatic logic [7:0] gf_mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_mul2(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  task automatic build_sbox();
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      sbox_tb[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                   ^ 8'h63;
    end
  endtask

  // full encryption of one block under the current key registers
  function automatic block_t aes_encrypt(input block_t plain);
    logic [7:0] w [60][4];
    logic [7:0] st [16];
    logic [7:0] nxt [16];
    logic [7:0] t [4];
    logic [7:0] f, rc, a0, a1, a2, a3, s;
    int nk, nr, kb;
    block_t res;
    nk = (key_mode == KEY_MODE_128) ? 4 : (key_mode == KEY_MODE_192) ? 6 : 8;
    nr = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      for (int b = 0; b < 4; b++) begin
        kb = 4 * i + b;
        w[i][b] = key_words[kb / 8][(kb % 8) * 8 +: 8];
      end
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      for (int b = 0; b < 4; b++) t[b] = w[i-1][b];
      if (i % nk == 0) begin
        f = t[0];
        t[0] = sbox_tb[t[1]] ^ rc;
        t[1] = sbox_tb[t[2]];
        t[2] = sbox_tb[t[3]];
        t[3] = sbox_tb[f];
        rc = gf_mul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        for (int b = 0; b < 4; b++) t[b] = sbox_tb[t[b]];
      end
      for (int b = 0; b < 4; b++) w[i][b] = w[i-nk][b] ^ t[b];
    end
    for (int i = 0; i < 16; i++) st[i] = plain[i*8 +: 8] ^ w[i/4][i%4];
    for (int rnd = 1; rnd <= nr; rnd++) begin
      // sub bytes with shift rows
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          nxt[4*c+r] = sbox_tb[st[4*((c+r)%4)+r]];
      st = nxt;
      // mix columns except in the last round
      if (rnd < nr)
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          s = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ s ^ gf_mul2(a0 ^ a1);
          st[4*c+1] = a1 ^ s ^ gf_mul2(a1 ^ a2);
          st[4*c+2] = a2 ^ s ^ gf_mul2(a2 ^ a3);
          st[4*c+3] = a3 ^ s ^ gf_mul2(a3 ^ a0);
        end
      for (int i = 0; i < 16; i++) st[i] ^= w[4*rnd + i/4][i%4];
    end
    for (int i = 0; i < 16; i++) res[i*8 +: 8] = st[i];
    return res;
  endfunction

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (plain_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= plain_q[0];
        in_tvalid <= 1'b1;
        cipher_q.push_back(aes_encrypt(plain_q[0]));
        void'(plain_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output stall
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected beat cipher=%h", out_tdata);
        failed = 1'b1;
      end else begin
        if (out_tdata[63:0] !== cipher_q[0][63:0]) begin
          $error("cipher_low expected %h actual %h", cipher_q[0][63:0], out_tdata[63:0]);
          failed = 1'b1;
        end
        if (out_tdata[127:64] !== cipher_q[0][127:64]) begin
          $error("cipher_high expected %h actual %h", cipher_q[0][127:64],
                 out_tdata[127:64]);
          failed = 1'b1;
        end
        void'(cipher_q.pop_front());
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_KEY_MODE) key_mode = val[1:0];
    else if (idx <= CFG_KEY_24_31) key_words[idx - 1] = val;
  endtask

  task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(CFG_KEY_MODE, {62'd0, mode});
    write_reg(CFG_KEY_0_7, k0);
    write_reg(CFG_KEY_8_15, k1);
    write_reg(CFG_KEY_16_23, k2);
    write_reg(CFG_KEY_24_31, k3);
  endtask

  task automatic wait_drained();
    while (plain_q.size() > 0 || in_tvalid || cipher_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) plain_q.push_back({rand64(), rand64()});
  endtask

  // run limit
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // stimulus
  initial begin
    failed         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    key_mode       = KEY_MODE_128;
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    out_tready = 1'b0;
    build_sbox();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset key, field extremes
    plain_q.push_back('0);
    plain_q.push_back('1);
    plain_q.push_back({64'h0, 64'hffff_ffff_ffff_ffff});
    plain_q.push_back({64'hffff_ffff_ffff_ffff, 64'h0});
    wait_drained();

    // fips-197 appendix c vectors, bytes little-endian in each half
    load_key(KEY_MODE_128, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'hdeadbeefdeadbeef, 64'h0123456789abcdef);
    plain_q.push_back({64'hffeeddccbbaa9988, 64'h7766554433221100});
    plain_q.push_back({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    wait_drained();
    load_key(KEY_MODE_192, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'h1716151413121110, 64'hffffffffffffffff);
    plain_q.push_back({64'hffeeddccbbaa9988, 64'h7766554433221100});
    plain_q.push_back('1);
    wait_drained();
    load_key(KEY_MODE_256, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    plain_q.push_back({64'hffeeddccbbaa9988, 64'h7766554433221100});
    plain_q.push_back('0);
    wait_drained();
    // unused key mode saturates to a 256-bit key; out-of-range index ignored
    load_key(2'd3, '1, '1, '1, '1);
    write_reg(3'd5, 64'h1234);
    write_reg(3'd7, 64'h5678);
    plain_q.push_back('0);
    plain_q.push_back('1);
    wait_drained();

    // random phases over key settings and idling profiles
    for (int ph = 0; ph < 16; ph++) begin
      unique case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      load_key(ph[3:2], rand64(), rand64(), rand64(), rand64());
      queue_random(125);
      wait_drained();
    end

    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/aes_enc_pkg.sv
rtl/core/aes_enc_round.sv
rtl/core/aes_enc_key.sv
rtl/core/aes_block_encrypt_core.sv
dv/aes_block_encrypt_core_tb.sv
